>>> rtl/segment_rectangle_intersect_assert.svh
// Assertion macros for the segment versus rectangle pipeline.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef SEGMENT_RECTANGLE_INTERSECT_ASSERT_SVH
`define SEGMENT_RECTANGLE_INTERSECT_ASSERT_SVH

`ifndef SYNTH
// The condition holds at every clock edge outside reset.
`define SRI_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed: always");
// When the trigger holds, the consequence holds in the next cycle.
`define SRI_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("assertion failed: next cycle");
`else
`define SRI_ASSERT_ALWAYS(label, cond)
`define SRI_ASSERT_NEXT(label, trig, cons)
`endif

`endif

>>> rtl/sri_pkg.sv
package sri_pkg;

	// One flag for each rectangle edge.
	typedef struct packed {
		logic top;
		logic right;
		logic bottom;
		logic left;
	} edge_flags_t;

	// Tests whether num/den lies in [0,1] from sign information alone.
	// A zero denominator never passes.
	function automatic logic unit_ok(
		input logic den_zero,
		input logic den_neg,
		input logic num_neg,
		input logic num_pos,
		input logic dmn_neg,
		input logic nmd_neg
	);
		logic ok;
		if (den_zero) begin
			ok = 1'b0;
		end else if (den_neg) begin
			ok = !num_pos && !nmd_neg;
		end else begin
			ok = !num_neg && !dmn_neg;
		end
		return ok;
	endfunction

endpackage

>>> rtl/sri_delta.sv
module sri_delta import sri_pkg::*; #(
	parameter int CW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [CW-1:0] start_x,
	input  logic signed [CW-1:0] start_y,
	input  logic signed [CW-1:0] end_x,
	input  logic signed [CW-1:0] end_y,
	input  logic signed [CW-1:0] rect_left,
	input  logic signed [CW-1:0] rect_top,
	input  logic        [CW-2:0] rect_width,
	input  logic        [CW-2:0] rect_height,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [CW:0]   rx_s1,
	output logic signed [CW:0]   ry_s1,
	output logic signed [CW+1:0] dxl_s1,
	output logic signed [CW+1:0] dxr_s1,
	output logic signed [CW+1:0] dyt_s1,
	output logic signed [CW+1:0] dyb_s1,
	output logic        [CW-2:0] wd_s1,
	output logic        [CW-2:0] ht_s1
);

	logic          v_s1;
	logic signed [CW:0]   sx_e, sy_e, ex_e, ey_e;
	logic signed [CW+1:0] sx_w, sy_w, lf_w, tp_w, wd_w, ht_w;

	// Explicit sign and zero extension of the coordinates and sizes.
	assign sx_e = {start_x[CW-1], start_x};
	assign sy_e = {start_y[CW-1], start_y};
	assign ex_e = {end_x[CW-1], end_x};
	assign ey_e = {end_y[CW-1], end_y};
	assign sx_w = {{2{start_x[CW-1]}}, start_x};
	assign sy_w = {{2{start_y[CW-1]}}, start_y};
	assign lf_w = {{2{rect_left[CW-1]}}, rect_left};
	assign tp_w = {{2{rect_top[CW-1]}}, rect_top};
	assign wd_w = {3'b000, rect_width};
	assign ht_w = {3'b000, rect_height};

	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Segment direction and the offsets of the rectangle sides from the start point.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_s1  <= ex_e - sx_e;
			ry_s1  <= ey_e - sy_e;
			dxl_s1 <= lf_w - sx_w;
			dxr_s1 <= lf_w + wd_w - sx_w;
			dyt_s1 <= tp_w - sy_w;
			dyb_s1 <= tp_w + ht_w - sy_w;
			wd_s1  <= rect_width;
			ht_s1  <= rect_height;
		end
	end

endmodule

>>> rtl/sri_prod.sv
module sri_prod import sri_pkg::*; #(
	parameter int CW = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [CW:0]     rx_s1,
	input  logic signed [CW:0]     ry_s1,
	input  logic signed [CW+1:0]   dxl_s1,
	input  logic signed [CW+1:0]   dxr_s1,
	input  logic signed [CW+1:0]   dyt_s1,
	input  logic signed [CW+1:0]   dyb_s1,
	input  logic        [CW-2:0]   wd_s1,
	input  logic        [CW-2:0]   ht_s1,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [2*CW+2:0] lry_s2,
	output logic signed [2*CW+2:0] rry_s2,
	output logic signed [2*CW+2:0] trx_s2,
	output logic signed [2*CW+2:0] brx_s2,
	output logic signed [2*CW:0]   denh_s2,
	output logic signed [2*CW:0]   denv_s2,
	output edge_flags_t            flags_s2
);

	logic                 v_s2;
	logic signed [CW-1:0] wd_e, ht_e;
	edge_flags_t          flags_d;

	// Parameter along the segment: q_perp / r_perp must lie in [0,1].
	function automatic logic perp_ok(
		input logic signed [CW+1:0] num,
		input logic signed [CW:0]   den
	);
		logic signed [CW+2:0] n3, d3, dmn, nmd;
		n3  = {num[CW+1], num};
		d3  = {{2{den[CW]}}, den};
		dmn = d3 - n3;
		nmd = n3 - d3;
		return unit_ok(den == '0, den[CW], num[CW+1], !num[CW+1] && (num != '0),
			dmn[CW+2], nmd[CW+2]);
	endfunction

	assign wd_e = {1'b0, wd_s1};
	assign ht_e = {1'b0, ht_s1};

	assign flags_d.top    = perp_ok(dyt_s1, ry_s1);
	assign flags_d.bottom = perp_ok(dyb_s1, ry_s1);
	assign flags_d.right  = perp_ok(dxr_s1, rx_s1);
	assign flags_d.left   = perp_ok(dxl_s1, rx_s1);

	assign in_ready  = !v_s2 || out_ready;
	assign out_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	// The cross-product terms for the corners and the denominators for the horizontal and vertical edges.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			lry_s2   <= dxl_s1 * ry_s1;
			rry_s2   <= dxr_s1 * ry_s1;
			trx_s2   <= dyt_s1 * rx_s1;
			brx_s2   <= dyb_s1 * rx_s1;
			denh_s2  <= ry_s1 * wd_e;
			denv_s2  <= rx_s1 * ht_e;
			flags_s2 <= flags_d;
		end
	end

endmodule

>>> rtl/sri_decide.sv
`include "segment_rectangle_intersect_assert.svh"

module sri_decide import sri_pkg::*; #(
	parameter int CW = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [2*CW+2:0] lry_s2,
	input  logic signed [2*CW+2:0] rry_s2,
	input  logic signed [2*CW+2:0] trx_s2,
	input  logic signed [2*CW+2:0] brx_s2,
	input  logic signed [2*CW:0]   denh_s2,
	input  logic signed [2*CW:0]   denv_s2,
	input  edge_flags_t            flags_s2,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   hit
);

	logic                   v_s3, v_s4, s4_ready;
	logic signed [2*CW+3:0] unt_s3, unr_s3, unb_s3, unl_s3;
	logic signed [2*CW:0]   denh_s3, denv_s3;
	edge_flags_t            flags_s3;
	logic                   hit_s4;
	logic signed [2*CW+4:0] dh5, dv5;
	logic                   hit_d;

	// Parameter along the edge: un / den must lie in [0,1].
	function automatic logic edge_ok(
		input logic signed [2*CW+3:0] num,
		input logic signed [2*CW+4:0] den
	);
		logic signed [2*CW+4:0] n5, dmn, nmd;
		n5  = {num[2*CW+3], num};
		dmn = den - n5;
		nmd = n5 - den;
		return unit_ok(den == '0, den[2*CW+4], num[2*CW+3],
			!num[2*CW+3] && (num != '0), dmn[2*CW+4], nmd[2*CW+4]);
	endfunction

	assign s4_ready  = !v_s4 || out_ready;
	assign in_ready  = !v_s3 || s4_ready;
	assign out_valid = v_s4;
	assign hit       = hit_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s3 <= in_valid;
			end
			if (s4_ready) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Cross product of the corner offset with the segment direction, per edge.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			unt_s3   <= {lry_s2[2*CW+2], lry_s2} - {trx_s2[2*CW+2], trx_s2};
			unr_s3   <= {rry_s2[2*CW+2], rry_s2} - {trx_s2[2*CW+2], trx_s2};
			unb_s3   <= {rry_s2[2*CW+2], rry_s2} - {brx_s2[2*CW+2], brx_s2};
			unl_s3   <= {lry_s2[2*CW+2], lry_s2} - {brx_s2[2*CW+2], brx_s2};
			denh_s3  <= denh_s2;
			denv_s3  <= denv_s2;
			flags_s3 <= flags_s2;
		end
	end

	// Horizontal edges run one way on top and the other way at the bottom,
	// so their denominators differ only in sign; likewise for the sides.
	assign dh5 = {{4{denh_s3[2*CW]}}, denh_s3};
	assign dv5 = {{4{denv_s3[2*CW]}}, denv_s3};

	assign hit_d = (flags_s3.top    && edge_ok(unt_s3, -dh5))
		|| (flags_s3.right  && edge_ok(unr_s3, dv5))
		|| (flags_s3.bottom && edge_ok(unb_s3, dh5))
		|| (flags_s3.left   && edge_ok(unl_s3, -dv5));

	always_ff @(posedge clk) begin
		if (v_s3 && s4_ready) begin
			hit_s4 <= hit_d;
		end
	end

	// A pair of zero denominators (parallel in both directions) never gives a hit.
	`SRI_ASSERT_NEXT(a_parallel, v_s3 && s4_ready && denh_s3 == '0 && denv_s3 == '0, !hit_s4)
	// With no edge passing the along-segment test, the result is a miss.
	`SRI_ASSERT_NEXT(a_no_flags, v_s3 && s4_ready && flags_s3 == '0, !hit_s4)
	// An item in the third stage moves on when the output register is empty.
	`SRI_ASSERT_NEXT(a_advance, v_s3 && !v_s4, v_s4)
	// An empty third stage always takes a beat.
	`SRI_ASSERT_ALWAYS(a_take, v_s3 || in_ready)

endmodule

>>> rtl/segment_rectangle_intersect.sv
// Segment versus axis-aligned rectangle test. Each input beat carries one
// segment and one rectangle; each output beat carries one hit flag that is set
// when the segment meets any of the four rectangle edges, touching counted, and
// with parallel or collinear edges counted as a miss. The datapath is a
// four-stage pipeline (offsets, six multipliers, cross-product differences,
// range compare into the output register), and a new beat is taken every
// cycle while the output side keeps up. Each stage stalls on its own, so
// bubbles close up behind a held result. All arithmetic is exact integer
// work with no rounding.
module segment_rectangle_intersect import sri_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	localparam int InBits  = 8 * COORD_WIDTH - 2,
	localparam int InWidth = ((InBits + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// start_x, start_y, end_x, end_y, rect_left, rect_top, rect_width,
	// rect_height, from the lowest bit up, zero padding above.
	input  logic [InWidth-1:0] s_axis_tdata,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// hit in bit 0, zero padding above.
	output logic [7:0]         m_axis_tdata
);

	localparam int CW = COORD_WIDTH;

	logic signed [CW-1:0]   start_x, start_y, end_x, end_y, rect_left, rect_top;
	logic        [CW-2:0]   rect_width, rect_height;

	logic                   v1, r1, v2, r2;
	logic signed [CW:0]     rx_s1, ry_s1;
	logic signed [CW+1:0]   dxl_s1, dxr_s1, dyt_s1, dyb_s1;
	logic        [CW-2:0]   wd_s1, ht_s1;
	logic signed [2*CW+2:0] lry_s2, rry_s2, trx_s2, brx_s2;
	logic signed [2*CW:0]   denh_s2, denv_s2;
	edge_flags_t            flags_s2;
	logic                   hit;

	// Unpack the input beat.
	assign start_x     = s_axis_tdata[0*CW +: CW];
	assign start_y     = s_axis_tdata[1*CW +: CW];
	assign end_x       = s_axis_tdata[2*CW +: CW];
	assign end_y       = s_axis_tdata[3*CW +: CW];
	assign rect_left   = s_axis_tdata[4*CW +: CW];
	assign rect_top    = s_axis_tdata[5*CW +: CW];
	assign rect_width  = s_axis_tdata[6*CW +: CW-1];
	assign rect_height = s_axis_tdata[7*CW-1 +: CW-1];

	sri_delta #(.CW(CW)) u_delta (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.rect_left   (rect_left),
		.rect_top    (rect_top),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.out_valid   (v1),
		.out_ready   (r1),
		.rx_s1       (rx_s1),
		.ry_s1       (ry_s1),
		.dxl_s1      (dxl_s1),
		.dxr_s1      (dxr_s1),
		.dyt_s1      (dyt_s1),
		.dyb_s1      (dyb_s1),
		.wd_s1       (wd_s1),
		.ht_s1       (ht_s1)
	);

	sri_prod #(.CW(CW)) u_prod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.rx_s1     (rx_s1),
		.ry_s1     (ry_s1),
		.dxl_s1    (dxl_s1),
		.dxr_s1    (dxr_s1),
		.dyt_s1    (dyt_s1),
		.dyb_s1    (dyb_s1),
		.wd_s1     (wd_s1),
		.ht_s1     (ht_s1),
		.out_valid (v2),
		.out_ready (r2),
		.lry_s2    (lry_s2),
		.rry_s2    (rry_s2),
		.trx_s2    (trx_s2),
		.brx_s2    (brx_s2),
		.denh_s2   (denh_s2),
		.denv_s2   (denv_s2),
		.flags_s2  (flags_s2)
	);

	sri_decide #(.CW(CW)) u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r2),
		.lry_s2    (lry_s2),
		.rry_s2    (rry_s2),
		.trx_s2    (trx_s2),
		.brx_s2    (brx_s2),
		.denh_s2   (denh_s2),
		.denv_s2   (denv_s2),
		.flags_s2  (flags_s2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.hit       (hit)
	);

	assign m_axis_tdata = {7'b0000000, hit};

endmodule

>>> verif/tb_segment_rectangle_intersect.sv
module tb_segment_rectangle_intersect;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CoordWidth   = 16;
	localparam int SizeWidth    = CoordWidth - 1;
	localparam int BeatWidth    = 128;
	localparam int IdlePercent  = 24;
	localparam int RandomItems  = 450;
	localparam int QuietFirst   = 250;
	localparam int QuietLast    = 350;
	localparam int HoldAt       = 100;
	localparam int HoldCycles   = 64;
	localparam int DrainCycles  = 8;
	localparam int StallLimit   = 1000;

	// Kinds of random query, weighted towards geometry near the rectangle.
	typedef enum int {
		QueryNear,
		QueryTouch,
		QueryAxis,
		QueryDegenerate,
		QueryWild
	} query_kind_t;

	// One segment and one rectangle, at the block's field widths.
	typedef struct {
		logic signed [CoordWidth-1:0] start_x;
		logic signed [CoordWidth-1:0] start_y;
		logic signed [CoordWidth-1:0] end_x;
		logic signed [CoordWidth-1:0] end_y;
		logic signed [CoordWidth-1:0] rect_left;
		logic signed [CoordWidth-1:0] rect_top;
		logic        [SizeWidth-1:0]  rect_width;
		logic        [SizeWidth-1:0]  rect_height;
	} seg_rect_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// start_x, start_y, end_x, end_y, rect_left, rect_top, rect_width,
	// rect_height, from the lowest bit up, zero padding above.
	logic [BeatWidth-1:0] s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// hit in bit 0, zero padding above.
	logic [7:0]           m_axis_tdata;

	seg_rect_t pending_queries[$];
	logic      expected_hits[$];
	seg_rect_t offered;
	int        beats_sent   = 0;
	int        results_seen = 0;
	int        hits_seen    = 0;
	int        hold_left    = 0;
	logic      hold_done    = 1'b0;
	int        mismatches   = 0;
	int        stall_count  = 0;

	segment_rectangle_intersect #(
		.COORD_WIDTH(CoordWidth)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// True when num/den lies in [0,1]; a zero denominator never passes.
	function automatic logic ratio_in_unit(longint num, longint den);
		if (den == 0) begin
			return 1'b0;
		end
		if (den > 0) begin
			return num >= 0 && den - num >= 0;
		end
		return num <= 0 && num - den >= 0;
	endfunction

	// Parametric cross-product test of segment a-b against edge c-d.
	function automatic logic edge_crossed(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy, longint dx, longint dy);
		longint rx  = bx - ax;
		longint ry  = by - ay;
		longint sx  = dx - cx;
		longint sy  = dy - cy;
		longint qx  = cx - ax;
		longint qy  = cy - ay;
		longint den = rx * sy - ry * sx;
		longint tn  = qx * sy - qy * sx;
		longint un  = qx * ry - qy * rx;
		return ratio_in_unit(tn, den) && ratio_in_unit(un, den);
	endfunction

	// Expected hit flag: any rectangle edge, right and bottom at left plus width and top plus height.
	function automatic logic predict_hit(seg_rect_t q);
		longint ax  = q.start_x;
		longint ay  = q.start_y;
		longint bx  = q.end_x;
		longint by  = q.end_y;
		longint lft = q.rect_left;
		longint top = q.rect_top;
		longint rgt = lft + longint'(q.rect_width);
		longint bot = top + longint'(q.rect_height);
		return edge_crossed(ax, ay, bx, by, lft, top, rgt, top) ||
			edge_crossed(ax, ay, bx, by, rgt, top, rgt, bot) ||
			edge_crossed(ax, ay, bx, by, rgt, bot, lft, bot) ||
			edge_crossed(ax, ay, bx, by, lft, bot, lft, top);
	endfunction

	function automatic seg_rect_t build_query(int sx, int sy, int ex, int ey,
			int lft, int top, int w, int h);
		seg_rect_t q;
		q.start_x     = sx[CoordWidth-1:0];
		q.start_y     = sy[CoordWidth-1:0];
		q.end_x       = ex[CoordWidth-1:0];
		q.end_y       = ey[CoordWidth-1:0];
		q.rect_left   = lft[CoordWidth-1:0];
		q.rect_top    = top[CoordWidth-1:0];
		q.rect_width  = w[SizeWidth-1:0];
		q.rect_height = h[SizeWidth-1:0];
		return q;
	endfunction

	// A coordinate within a margin of [lo, hi], kept inside the signed range.
	function automatic int near_range(int lo, int hi, int margin);
		int v = lo - margin + int'($urandom_range(0, hi - lo + 2 * margin));
		if (v < -32768) begin
			v = -32768;
		end else if (v > 32767) begin
			v = 32767;
		end
		return v;
	endfunction

	function automatic seg_rect_t random_query(query_kind_t kind);
		int lft = int'($urandom_range(0, 4000)) - 2000;
		int top = int'($urandom_range(0, 4000)) - 2000;
		int w   = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2000))
			: int'($urandom_range(0, 400));
		int h   = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2000))
			: int'($urandom_range(0, 400));
		int sx  = near_range(lft, lft + w, 300);
		int sy  = near_range(top, top + h, 300);
		int ex  = near_range(lft, lft + w, 300);
		int ey  = near_range(top, top + h, 300);
		case (kind)
			QueryTouch: begin
				// End point lands exactly on an edge or a corner.
				case ($urandom_range(0, 4))
					0: begin ex = lft;     ey = near_range(top, top + h, 0); end
					1: begin ex = lft + w; ey = near_range(top, top + h, 0); end
					2: begin ey = top;     ex = near_range(lft, lft + w, 0); end
					3: begin ey = top + h; ex = near_range(lft, lft + w, 0); end
					default: begin
						ex = $urandom_range(0, 1) ? lft : lft + w;
						ey = $urandom_range(0, 1) ? top : top + h;
					end
				endcase
			end
			QueryAxis: begin
				// Horizontal or vertical segments, often collinear with an edge.
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 2))
						0: sy = top;
						1: sy = top + h;
						default: ;
					endcase
					ey = sy;
				end else begin
					case ($urandom_range(0, 2))
						0: sx = lft;
						1: sx = lft + w;
						default: ;
					endcase
					ex = sx;
				end
			end
			QueryDegenerate: begin
				// Point segments, or rectangles flattened in one or both axes.
				case ($urandom_range(0, 3))
					0: begin ex = sx; ey = sy; end
					1: w = 0;
					2: h = 0;
					default: begin w = 0; h = 0; end
				endcase
			end
			QueryWild: begin
				return build_query($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 32767), $urandom_range(0, 32767));
			end
			default: ;
		endcase
		return build_query(sx, sy, ex, ey, lft, top, w, h);
	endfunction

	// Sender: offers queued queries, idling at random outside the quiet stretch.
	always @(posedge clk or negedge arst_n) begin
		logic quiet;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			quiet = beats_sent >= QuietFirst && beats_sent < QuietLast;
			if (s_axis_tvalid && s_axis_tready) begin
				expected_hits.push_back(predict_hit(offered));
				beats_sent <= beats_sent + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_queries.size() != 0 &&
						(quiet || $urandom_range(0, 99) >= IdlePercent)) begin
					offered = pending_queries.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {2'b00, offered.rect_height, offered.rect_width,
						offered.rect_top, offered.rect_left, offered.end_y, offered.end_x,
						offered.start_y, offered.start_x};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result beat and stalls at random, with one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		logic quiet;
		logic want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			quiet = results_seen >= QuietFirst && results_seen < QuietLast;
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				hits_seen    <= hits_seen + m_axis_tdata[0];
				if (expected_hits.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got hit %0b",
						$time, m_axis_tdata[0]);
					mismatches++;
				end else begin
					want = expected_hits.pop_front();
					if (m_axis_tdata[0] !== want) begin
						$display("%0t: hit mismatch, expected %0b, got %0b",
							$time, want, m_axis_tdata[0]);
						mismatches++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left     <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && results_seen >= HoldAt) begin
				hold_done     <= 1'b1;
				hold_left     <= HoldCycles;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= quiet || $urandom_range(0, 99) >= IdlePercent;
			end
		end
	end

	// Watchdog on cycles in which neither side moves a beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_count <= 0;
			end else if (stall_count >= StallLimit) begin
				$display("Timeout after %0d cycles without a beat", StallLimit);
				$display("CHECKS FAILED");
				$finish;
			end else begin
				stall_count <= stall_count + 1;
			end
		end
	end

	initial begin
		// Directed: clear crossings and misses, parallel and collinear edges,
		// point segments, flattened rectangles, touching, and field extremes.
		pending_queries.push_back(build_query(-80, 80, 240, 80, 0, 0, 160, 160));
		pending_queries.push_back(build_query(-80, -80, -16, 300, 0, 0, 160, 160));
		pending_queries.push_back(build_query(16, 16, 144, 144, 0, 0, 160, 160));
		pending_queries.push_back(build_query(-16, 0, 176, 0, 0, 0, 160, 160));
		pending_queries.push_back(build_query(32, 0, 128, 0, 0, 0, 160, 160));
		pending_queries.push_back(build_query(-80, -40, 240, -40, 0, 0, 160, 160));
		pending_queries.push_back(build_query(0, 80, 0, 80, 0, 0, 160, 160));
		pending_queries.push_back(build_query(-80, 80, 80, 80, 0, 0, 0, 160));
		pending_queries.push_back(build_query(80, -80, 80, 80, 0, 0, 160, 0));
		pending_queries.push_back(build_query(-80, 0, 80, 0, 0, 0, 0, 0));
		pending_queries.push_back(build_query(-80, 80, 0, 80, 0, 0, 160, 160));
		pending_queries.push_back(build_query(-80, -80, 0, 0, 0, 0, 160, 160));
		pending_queries.push_back(build_query(320, 160, 160, 160, 0, 0, 160, 160));
		pending_queries.push_back(build_query(-32768, -32768, 32767, 32767,
			32767, 32767, 32767, 32767));
		pending_queries.push_back(build_query(-32768, 32767, 32767, -32768,
			-32768, -32768, 32767, 32767));
		pending_queries.push_back(build_query(32767, 32767, 32767, -32768,
			-32768, -32768, 32767, 32767));
		pending_queries.push_back(build_query(0, 0, 0, 0, 0, 0, 0, 0));
		pending_queries.push_back(build_query(-1, -1, -1, -1, -1, -1, 32767, 32767));
		pending_queries.push_back(build_query(-32768, 0, 32767, 0, -32768, -32768, 0, 32767));
		pending_queries.push_back(build_query(-16, -16, 16, 16, -32768, -32768, 32767, 32767));

		// Random: mostly geometry around the rectangle, some full-range noise.
		for (int i = 0; i < RandomItems; i++) begin
			int pick;
			pick = int'($urandom_range(0, 19));
			if (pick inside {[0:9]}) begin
				pending_queries.push_back(random_query(QueryNear));
			end else if (pick inside {[10:12]}) begin
				pending_queries.push_back(random_query(QueryTouch));
			end else if (pick inside {[13:14]}) begin
				pending_queries.push_back(random_query(QueryAxis));
			end else if (pick inside {[15:16]}) begin
				pending_queries.push_back(random_query(QueryDegenerate));
			end else begin
				pending_queries.push_back(random_query(QueryWild));
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_queries.size() != 0 || s_axis_tvalid) begin
			@(posedge clk);
		end
		while (expected_hits.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);

		$display("Checked %0d segment and rectangle queries: %0d hits, %0d misses.",
			results_seen, hits_seen, results_seen - hits_seen);
		$display("Both sides stalled at random, with one long output hold-off of %0d cycles.",
			HoldCycles);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
